/* hdl/rcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF chunk walker package
// Tags, status and kind codes, register indexes and the result record that
// the walker, the result queue and the top level share.
// ----------------------------------------------------------------------------
package rcw_pkg;

  localparam int DEFAULT_MAX_DEPTH = 8;
  localparam int DEFAULT_POS_BITS  = 32;

  localparam logic [31:0] TAG_RIFF           = 32'h4646_4952;
  localparam logic [31:0] TAG_FORM           = 32'h2056_4546;
  localparam logic [31:0] TAG_LIST           = 32'h5453_494c;
  localparam logic [31:0] DEFAULT_TARGET_TAG = 32'h494b_4e42;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TAG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_FORM  = 2'd2;

  localparam int TDATA_W = 144;
  localparam int TUSER_W = 1;

  typedef enum logic {
    KIND_PAYLOAD,
    KIND_SUMMARY
  } kind_e;

  typedef enum logic [2:0] {
    STATUS_OK,
    STATUS_SHORT,
    STATUS_NOT_RIFF,
    STATUS_BAD_FORM,
    STATUS_TOO_DEEP
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [31:0] payload_offset;
    logic [31:0] match_number;
    logic [31:0] declared_size;
    logic        last_in_chunk;
    status_e     status;
    logic [31:0] hit_total;
  } result_t;

endpackage

/* hdl/rcw_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF chunk walker core
// Holds the configuration registers and the walk state, and turns each
// accepted byte into at most two results in the same cycle.
// ----------------------------------------------------------------------------
module rcw_walker #(
  parameter int MAX_DEPTH = rcw_pkg::DEFAULT_MAX_DEPTH,
  parameter int POS_BITS  = rcw_pkg::DEFAULT_POS_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           step_i,
  input  logic [7:0]                     byte_i,
  output rcw_pkg::result_t [1:0]         res_o,
  output logic [1:0]                     res_valid_o
);
  import rcw_pkg::*;

  localparam int PW  = POS_BITS;
  localparam int LW  = (POS_BITS > 32) ? POS_BITS : 32;
  localparam int EW  = LW + 1;
  localparam int LVW = $clog2(MAX_DEPTH + 1);
  localparam int SW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef enum logic [1:0] {
    PH_FILE_HDR,
    PH_CHUNK_HDR,
    PH_PAYLOAD,
    PH_HALTED
  } phase_e;

  logic [31:0]    target_tag_q, file_length_q;
  logic           check_form_q;
  logic [PW-1:0]  pos_q, pos_d;
  logic [3:0]     hc_q, hc_d;
  logic [LVW-1:0] lev_q, lev_d;
  logic [PW-1:0]  chunk_end_q, chunk_end_d;
  phase_e         phase_q, phase_d;
  logic [31:0]    offset_q, offset_d;
  logic [31:0]    size_q, size_d;
  logic [31:0]    hits_q, hits_d;
  status_e        err_q, err_d;
  logic           match_q, match_d;
  logic           ended_q, ended_d;
  logic [7:0]     hdr_q [8];
  logic [7:0]     hdr_d [8];
  logic [PW-1:0]  stack_q [MAX_DEPTH];
  logic [PW-1:0]  stack_d [MAX_DEPTH];

  logic [LW-1:0]  len_ext, pos_max;
  logic [PW-1:0]  eff;
  logic [PW:0]    p1;
  logic [LVW-1:0] lev_w;
  logic [PW-1:0]  region_end;
  logic [31:0]    tag_w, size_w, word_w;
  logic [EW-1:0]  cend_full;
  logic [PW-1:0]  cend;
  logic           sb_go, sb_match;
  logic [PW-1:0]  sb_end;
  result_t        pay, summ;
  logic           emit, fin;

  assign len_ext = LW'(file_length_q);
  assign pos_max = LW'({PW{1'b1}});
  assign eff     = PW'((len_ext < pos_max) ? len_ext : pos_max);
  assign p1      = {1'b0, pos_q} + (PW+1)'(1);

  // Nested region ends never grow towards the top, so the lowest entry that
  // has been reached closes it and every region above it.
  always_comb begin
    lev_w = lev_q;
    for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
      if ((LVW'(i) < lev_q) && (pos_q >= stack_q[i])) begin
        lev_w = LVW'(i);
      end
    end
  end

  assign region_end = (lev_w != '0) ? stack_q[SW'(lev_w - LVW'(1))] : eff;
  assign tag_w      = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
  assign size_w     = {byte_i, hdr_q[6], hdr_q[5], hdr_q[4]};
  assign word_w     = {byte_i, hdr_q[2], hdr_q[1], hdr_q[0]};
  assign cend_full  = EW'(p1) + EW'(size_w);
  assign cend       = (cend_full > EW'(region_end)) ? region_end : PW'(cend_full);

  always_comb begin
    pos_d       = pos_q;
    hc_d        = hc_q;
    lev_d       = lev_q;
    chunk_end_d = chunk_end_q;
    phase_d     = phase_q;
    offset_d    = offset_q;
    size_d      = size_q;
    hits_d      = hits_q;
    err_d       = err_q;
    match_d     = match_q;
    ended_d     = ended_q;
    hdr_d       = hdr_q;
    stack_d     = stack_q;
    sb_go       = 1'b0;
    sb_match    = 1'b0;
    sb_end      = chunk_end_q;
    emit        = 1'b0;
    fin         = 1'b0;
    pay         = '0;
    pay.kind    = KIND_PAYLOAD;

    if (step_i && !ended_q) begin
      if (pos_q >= eff) begin
        ended_d = 1'b1;
        fin     = 1'b1;
      end else begin
        unique case (phase_q)
          PH_FILE_HDR: begin
            if (!pos_q[2]) begin
              hdr_d[{1'b0, pos_q[1:0]}] = byte_i;
            end
            if (pos_q == PW'(3)) begin
              if (word_w != TAG_RIFF) begin
                if (err_q == STATUS_OK) err_d = STATUS_NOT_RIFF;
                phase_d = PH_HALTED;
              end
            end else if (pos_q == PW'(11)) begin
              if (check_form_q && (word_w != TAG_FORM)) begin
                if (err_q == STATUS_OK) err_d = STATUS_BAD_FORM;
                phase_d = PH_HALTED;
              end else begin
                phase_d = PH_CHUNK_HDR;
              end
              hc_d = '0;
            end
          end
          PH_CHUNK_HDR, PH_PAYLOAD: begin
            lev_d = lev_w;
            if (lev_w != lev_q) begin
              phase_d = PH_CHUNK_HDR;
              hc_d    = '0;
              match_d = 1'b0;
            end
            if (phase_d == PH_PAYLOAD) begin
              if (match_d) begin
                emit               = 1'b1;
                pay.payload_byte   = byte_i;
                pay.payload_offset = offset_q;
                pay.match_number   = hits_q - 32'd1;
                pay.declared_size  = size_q;
                pay.last_in_chunk  = (p1 == {1'b0, chunk_end_q});
                offset_d           = offset_q + 32'd1;
              end
              if (p1 >= {1'b0, chunk_end_q}) begin
                phase_d = PH_CHUNK_HDR;
                hc_d    = '0;
                match_d = 1'b0;
              end
            end else if ((hc_d == '0) &&
                         (({1'b0, pos_q} + (PW+1)'(8)) > {1'b0, region_end})) begin
              // Too few bytes left in the region for a header: skip them.
            end else if (hc_d < 4'd8) begin
              hdr_d[hc_d[2:0]] = byte_i;
              hc_d = hc_d + 4'd1;
              if (hc_d == 4'd8) begin
                if (tag_w == TAG_LIST) begin
                  if ({1'b0, cend} >= ({1'b0, pos_q} + (PW+1)'(5))) begin
                    chunk_end_d = cend;
                  end else begin
                    sb_go  = 1'b1;
                    sb_end = cend;
                  end
                end else if (tag_w == target_tag_q) begin
                  size_d   = size_w;
                  offset_d = '0;
                  hits_d   = hits_q + 32'd1;
                  sb_go    = 1'b1;
                  sb_end   = cend;
                  sb_match = 1'b1;
                end else begin
                  sb_go  = 1'b1;
                  sb_end = cend;
                end
              end
            end else begin
              hc_d = hc_d + 4'd1;
              if (hc_d == 4'd12) begin
                hc_d = '0;
                if (lev_w < LVW'(MAX_DEPTH)) begin
                  stack_d[SW'(lev_w)] = chunk_end_q;
                  lev_d   = lev_w + LVW'(1);
                  phase_d = PH_CHUNK_HDR;
                end else begin
                  if (err_q == STATUS_OK) err_d = STATUS_TOO_DEEP;
                  sb_go  = 1'b1;
                  sb_end = chunk_end_q;
                end
              end
            end
            if (sb_go) begin
              hc_d = '0;
              if ({1'b0, sb_end} > p1) begin
                chunk_end_d = sb_end;
                phase_d     = PH_PAYLOAD;
                match_d     = sb_match;
              end else begin
                phase_d = PH_CHUNK_HDR;
                match_d = 1'b0;
              end
            end
          end
          PH_HALTED: begin
          end
          default: begin
          end
        endcase
        pos_d = PW'(p1);
        if (PW'(p1) == eff) begin
          ended_d = 1'b1;
          fin     = 1'b1;
        end
      end
    end

    summ           = '0;
    summ.kind      = KIND_SUMMARY;
    summ.status    = (eff < PW'(12)) ? STATUS_SHORT : err_d;
    summ.hit_total = hits_d;
  end

  always_comb begin
    res_o       = '0;
    res_valid_o = 2'b00;
    if (emit) begin
      res_o[0]       = pay;
      res_valid_o[0] = 1'b1;
      if (fin) begin
        res_o[1]       = summ;
        res_valid_o[1] = 1'b1;
      end
    end else if (fin) begin
      res_o[0]       = summ;
      res_valid_o[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_tag_q  <= DEFAULT_TARGET_TAG;
      file_length_q <= '0;
      check_form_q  <= 1'b1;
      pos_q         <= '0;
      hc_q          <= '0;
      lev_q         <= '0;
      chunk_end_q   <= '0;
      phase_q       <= PH_FILE_HDR;
      offset_q      <= '0;
      size_q        <= '0;
      hits_q        <= '0;
      err_q         <= STATUS_OK;
      match_q       <= 1'b0;
      ended_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TARGET_TAG:  target_tag_q  <= cfg_data_i;
          CFG_FILE_LENGTH: file_length_q <= cfg_data_i;
          CFG_CHECK_FORM:  check_form_q  <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      pos_q       <= pos_d;
      hc_q        <= hc_d;
      lev_q       <= lev_d;
      chunk_end_q <= chunk_end_d;
      phase_q     <= phase_d;
      offset_q    <= offset_d;
      size_q      <= size_d;
      hits_q      <= hits_d;
      err_q       <= err_d;
      match_q     <= match_d;
      ended_q     <= ended_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q   <= hdr_d;
    stack_q <= stack_d;
  end

endmodule

/* hdl/rcw_res_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF chunk walker result queue
// A four-entry queue that takes up to two results in a cycle and hands out
// one result per transaction.
// ----------------------------------------------------------------------------
module rcw_res_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rcw_pkg::result_t [1:0] res_i,
  input  logic [1:0]             push_i,
  output logic                   room_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output rcw_pkg::result_t       data_o
);
  import rcw_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  result_t         mem_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   n_push;
  logic            pop;

  assign n_push  = CW'(push_i[0]) + CW'(push_i[1]);
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CW'(DEPTH - 2));
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + AW'(n_push);
      rd_q  <= rd_q + AW'(pop);
      cnt_q <= cnt_q + n_push - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i[0]) mem_q[wr_q] <= res_i[0];
    if (push_i[1]) mem_q[wr_q + AW'(1)] <= res_i[1];
  end

endmodule

/* hdl/riff_chunk_walker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF chunk walker
// Walks a RIFF byte stream, descends into LIST chunks and streams out the
// payload bytes of chunks whose tag matches, then an end-of-file summary.
// ----------------------------------------------------------------------------
// The block takes one file byte per clock cycle while the result queue has
// room: each byte is walked by the core in the cycle it is accepted, and its
// results (at most a payload byte and then the summary) are written into a
// four-entry result queue, which the output side reads one transaction per
// cycle. Input ready is held low only while the queue has room for fewer
// than two results, so a stalled output side throttles the input once it
// fills. Results are registered in the queue before reaching the output.
// The file length must be written before the first byte; once the summary
// has been sent, further bytes are absorbed without result until reset.
module riff_chunk_walker_top
  import rcw_pkg::*;
#(
  parameter int MAX_DEPTH = rcw_pkg::DEFAULT_MAX_DEPTH,
  parameter int POS_BITS  = rcw_pkg::DEFAULT_POS_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // data_byte
  input  logic [7:0]                    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // payload_byte, payload_offset, match_number, declared_size, status,
  // hit_total, zero fill
  output logic [rcw_pkg::TDATA_W-1:0]   m_axis_tdata,
  // kind
  output logic [rcw_pkg::TUSER_W-1:0]   m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  result_t [1:0] res;
  logic [1:0]    res_valid;
  result_t       head;
  logic          step;

  assign cfg_ready_o = 1'b1;
  assign step        = s_axis_tvalid && s_axis_tready;

  rcw_walker #(
    .MAX_DEPTH (MAX_DEPTH),
    .POS_BITS  (POS_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .byte_i      (s_axis_tdata),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  rcw_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .push_i  (res_valid),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (head)
  );

  assign m_axis_tdata = {5'b0, head.hit_total, head.status, head.declared_size,
                         head.match_number, head.payload_offset, head.payload_byte};
  assign m_axis_tuser = TUSER_W'(head.kind);
  assign m_axis_tlast = head.last_in_chunk;

endmodule

/* hdl/rcw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF chunk walker port checker
// Watches the ports of the top level for result ordering and field contents.
// ----------------------------------------------------------------------------
module rcw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [7:0]                    s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rcw_pkg::TDATA_W-1:0]   m_axis_tdata,
  input logic [rcw_pkg::TUSER_W-1:0]   m_axis_tuser,
  input logic                          m_axis_tlast,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [rcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [31:0]                   cfg_data_i
);
  import rcw_pkg::*;

  logic out_tr;
  assign out_tr = m_axis_tvalid && m_axis_tready;

  // The summary is the final result, so nothing stays queued behind it.
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_tr && m_axis_tuser[0] |=> !m_axis_tvalid)
    else $error("result queued after summary");

  a_summary_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast && (m_axis_tdata[103:0] == '0))
    else $error("summary carries payload fields");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[TDATA_W-1:104] == '0))
    else $error("payload carries summary fields");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind riff_chunk_walker_top rcw_checker u_rcw_checker (.*);
